[rtl/weighted_crc32_key_to_server_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the weighted CRC-32 key to server block
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_CRC32_KEY_TO_SERVER_TOP_MACROS_SVH
`define WEIGHTED_CRC32_KEY_TO_SERVER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge outside reset.
`define WCKS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("wcks assertion failed");

// An implication checked at every clock edge outside reset.
`define WCKS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wcks assertion failed");

`else

`define WCKS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define WCKS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/wcks_pkg.sv]
// ----------------------------------------------------------------------------
// wcks_pkg
// Types and constants shared by the key to server selector modules.
// ----------------------------------------------------------------------------
package wcks_pkg;

	// Default number of buckets in the table.
	localparam int BUCKET_DEPTH_DEFAULT = 1024;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// Field widths fixed by the interface.
	localparam int HASH_W   = 15;
	localparam int WEIGHT_W = 11;
	localparam int SID_W    = 8;
	localparam int INDEX_W  = 10;
	localparam int SRVCNT_W = 9;

	localparam logic [SRVCNT_W-1:0] SERVER_COUNT_MAX = '1;

	// Command codes.
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_KEY = 1'b1;

	// Result kinds.
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// Status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	// Input word.
	typedef struct packed {
		logic                command;
		logic [SID_W-1:0]    server_id;
		logic [WEIGHT_W-1:0] weight;
		logic [7:0]          key_byte;
		logic                byte_valid;
		logic                key_last;
	} in_item_t;

	// Result word.
	typedef struct packed {
		logic               kind;
		logic [SID_W-1:0]   chosen_server;
		logic [INDEX_W-1:0] bucket_index;
		logic [HASH_W-1:0]  hash_value;
		logic [1:0]         status;
	} out_item_t;

	// Classified operation passed from the front part to the back part.
	typedef struct packed {
		logic                is_add;
		logic [SID_W-1:0]    server_id;
		logic [WEIGHT_W-1:0] weight;
		logic [HASH_W-1:0]   hash;
	} op_t;

endpackage

[rtl/wcks_ram.sv]
// ----------------------------------------------------------------------------
// wcks_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wcks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/wcks_front.sv]
// ----------------------------------------------------------------------------
// wcks_front
// Accepts input words, runs the CRC-32 over key bytes and classifies words.
// ----------------------------------------------------------------------------
module wcks_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  wcks_pkg::in_item_t item,
	output logic              push,
	output wcks_pkg::op_t     push_op,
	input  logic              queue_full
);
	import wcks_pkg::*;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	logic [31:0]       crc_q;
	logic [31:0]       crc_next;
	logic [31:0]       crc_inv;
	logic [HASH_W-1:0] hash_raw;
	logic              accept;

	// One byte through the reflected CRC, one bit per step.
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;

	// Next CRC value and the hash taken from it.
	always_comb begin
		crc_next = item.byte_valid ? crc_feed(crc_q, item.key_byte) : crc_q;
		crc_inv  = ~crc_next;
		hash_raw = crc_inv[30:16];
	end

	// Adds and key ends go to the back part; plain key bytes stop here.
	always_comb begin
		push              = accept && ((item.command == CMD_ADD) || item.key_last);
		push_op.is_add    = (item.command == CMD_ADD);
		push_op.server_id = item.server_id;
		push_op.weight    = item.weight;
		push_op.hash      = (hash_raw == '0) ? HASH_W'(1) : hash_raw;
	end

	// CRC register; an add leaves it untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '1;
		end else if (accept && (item.command == CMD_KEY)) begin
			crc_q <= item.key_last ? '1 : crc_next;
		end
	end

endmodule

[rtl/wcks_queue.sv]
// ----------------------------------------------------------------------------
// wcks_queue
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module wcks_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wcks_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output wcks_pkg::op_t head_op
);
	import wcks_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (fill_q == CW'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_op    = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/wcks_back.sv]
// ----------------------------------------------------------------------------
// wcks_back
// Carries out adds and lookups: table fill, modulo by bucket count, table read.
// ----------------------------------------------------------------------------
`include "weighted_crc32_key_to_server_top_macros.svh"

module wcks_back #(
	parameter int BUCKET_DEPTH = wcks_pkg::BUCKET_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  wcks_pkg::op_t      head_op,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output wcks_pkg::out_item_t result
);
	import wcks_pkg::*;

	localparam int IW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int CW = $clog2(BUCKET_DEPTH + 1);
	localparam int SW = ((CW > WEIGHT_W) ? CW : WEIGHT_W) + 1;
	localparam int STEP_W = $clog2(HASH_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [SRVCNT_W-1:0] servers_q;
	logic [IW-1:0]       fill_addr_q;
	logic [WEIGHT_W-1:0] fill_left_q;
	logic [CW-1:0]       rem_q;
	logic [HASH_W-1:0]   dividend_q;
	logic [STEP_W-1:0]   step_q;
	logic [IW-1:0]       idx_q;
	logic                use_ram_q;
	out_item_t           res_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic [SW-1:0]       add_sum;
	logic                overflow;
	logic [CW:0]         rem_shift;
	logic [CW:0]         rem_sub;
	logic [CW-1:0]       rem_next;
	logic [IW+INDEX_W-1:0] idx_wide;
	logic [CW+INDEX_W-1:0] count_wide;
	logic                out_free;
	logic [SID_W-1:0]    ram_rdata;
	logic                ram_we;
	logic                ram_re;
	out_item_t           emit_item;

	// Overflow check on an add.
	assign add_sum  = SW'(count_q) + SW'(head_op.weight);
	assign overflow = (add_sum > SW'(BUCKET_DEPTH));

	// One restoring division step per cycle.
	always_comb begin
		rem_shift = {rem_q, dividend_q[HASH_W-1]};
		rem_sub   = rem_shift - {1'b0, count_q};
		rem_next  = (rem_shift >= {1'b0, count_q}) ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
	end

	// Low ten bits of the bucket indexes reported in results.
	assign idx_wide   = {{INDEX_W{1'b0}}, idx_q};
	assign count_wide = {{INDEX_W{1'b0}}, count_q};

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign out_free = !out_valid_q || result_ready;
	assign ram_we   = (state_q == ST_FILL);
	assign ram_re   = (state_q == ST_READ);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Word for the output register, with the table entry where one was read.
	always_comb begin
		emit_item = res_q;
		if (use_ram_q) begin
			emit_item.chosen_server = ram_rdata;
		end
	end

	wcks_ram #(
		.WIDTH(SID_W),
		.DEPTH(BUCKET_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_addr_q),
		.wdata(res_q.chosen_server),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			servers_q   <= '0;
			fill_left_q <= '0;
			out_valid_q <= 1'b0;
			fill_addr_q <= '0;
			rem_q       <= '0;
			dividend_q  <= '0;
			step_q      <= '0;
			idx_q       <= '0;
			use_ram_q   <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						use_ram_q <= 1'b0;
						if (head_op.is_add) begin
							res_q.kind          <= KIND_ADD;
							res_q.chosen_server <= head_op.server_id;
							res_q.hash_value    <= '0;
							state_q             <= ST_EMIT;
							if (overflow) begin
								res_q.bucket_index <= '0;
								res_q.status       <= STATUS_OVERFLOW;
								fill_left_q        <= '0;
							end else begin
								res_q.bucket_index <= count_wide[INDEX_W-1:0];
								res_q.status       <= STATUS_OK;
								fill_addr_q        <= count_q[IW-1:0];
								fill_left_q        <= head_op.weight;
								count_q            <= add_sum[CW-1:0];
								if (servers_q != SERVER_COUNT_MAX) begin
									servers_q <= servers_q + 1'b1;
								end
							end
						end else begin
							res_q.kind       <= KIND_LOOKUP;
							res_q.hash_value <= head_op.hash;
							fill_left_q      <= '0;
							if (count_q == '0) begin
								res_q.chosen_server <= '0;
								res_q.bucket_index  <= '0;
								res_q.status        <= STATUS_EMPTY;
								state_q             <= ST_EMIT;
							end else if (servers_q > SRVCNT_W'(1)) begin
								rem_q      <= '0;
								dividend_q <= head_op.hash;
								step_q     <= '0;
								state_q    <= ST_DIV;
							end else begin
								idx_q   <= '0;
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_DIV: begin
					rem_q      <= rem_next;
					dividend_q <= dividend_q << 1;
					step_q     <= step_q + 1'b1;
					if (step_q == STEP_W'(HASH_W - 1)) begin
						idx_q   <= rem_next[IW-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					res_q.bucket_index <= idx_wide[INDEX_W-1:0];
					res_q.status       <= STATUS_OK;
					use_ram_q          <= 1'b1;
					state_q            <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q   <= emit_item;
						state_q <= (fill_left_q != '0) ? ST_FILL : ST_IDLE;
					end
				end
				ST_FILL: begin
					fill_addr_q <= fill_addr_q + 1'b1;
					fill_left_q <= fill_left_q - 1'b1;
					if (fill_left_q == WEIGHT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The bucket count never exceeds the table depth.
	`WCKS_ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= CW'(BUCKET_DEPTH))

	// The remainder stays below the divisor throughout the division.
	`WCKS_ASSERT_IMPLY(a_rem_below_count, clk, arst_n, state_q == ST_DIV, rem_q < count_q)

	// A fill writes only below the bucket count.
	`WCKS_ASSERT_IMPLY(a_fill_below_count, clk, arst_n, state_q == ST_FILL,
		CW'(fill_addr_q) < count_q)

	// A new result is loaded only when the output register is free.
	`WCKS_ASSERT_IMPLY(a_no_overwrite, clk, arst_n,
		out_valid_q && !result_ready, ##1 $stable(out_q) && out_valid_q)

endmodule

[rtl/weighted_crc32_key_to_server_top.sv]
// ----------------------------------------------------------------------------
// weighted_crc32_key_to_server_top
// Weighted bucket table with CRC-32 key hashing and server selection.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on item / item_valid / item_ready. An add word puts a
//   server into weight consecutive buckets; key words stream bytes through the
//   CRC, one per cycle while the queue has room; key_last starts a lookup.
//   Result words leave on result / result_valid / result_ready, one for every
//   add and every key end, in the order the input words were taken.
// Timing:
//   Key bytes are taken at one per cycle while the four-entry queue has room.
//   The back part emits the result of an add and then writes its buckets
//   one at a time through the single table write port. A lookup reads the
//   table once, after a bit-serial modulo by the bucket count when more than
//   one server is present; an empty table gives no read.
// Reset:
//   arst_n clears the CRC to all ones, the bucket and server counts, the
//   queue and the output register. The table contents are not cleared.
// Stalls:
//   While result_ready is low the result is held; the back part then stops at
//   its next result, the queue fills, and item_ready falls once it is full.
// ----------------------------------------------------------------------------
module weighted_crc32_key_to_server_top #(
	parameter int BUCKET_DEPTH = wcks_pkg::BUCKET_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  wcks_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output wcks_pkg::out_item_t result
);
	import wcks_pkg::*;

	logic push;
	op_t  push_op;
	logic queue_full;
	logic pop;
	logic head_valid;
	op_t  head_op;

	// Front part: CRC and classification.
	wcks_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.push      (push),
		.push_op   (push_op),
		.queue_full(queue_full)
	);

	// Queue between the two parts.
	wcks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_op   (head_op)
	);

	// Back part: table, modulo and result register.
	wcks_back #(
		.BUCKET_DEPTH(BUCKET_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_op     (head_op),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule
